>>> rtl/tqvg_pkg.sv
// ----------------------------------------------------------------------------
// Torus quad vertex generator package
// Shared widths, codes, cell record, angle arithmetic and the sine and cosine
// tables, which are built at elaboration.
// ----------------------------------------------------------------------------
package tqvg_pkg;

  localparam int ANGLE_STEPS = 360;
  localparam int ANG_W       = $clog2(ANGLE_STEPS);
  localparam int IN_ANG_W    = 9;
  localparam int STEP_W      = 9;
  localparam int RADIUS_W    = 16;
  localparam int TRIG_W      = 16;
  localparam int POS_W       = 18;
  localparam int CORNER_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int RING_W      = RADIUS_W + TRIG_W + 2;
  localparam int TERM_W      = RADIUS_W + TRIG_W + 1;
  localparam int PROD_W      = RING_W + TRIG_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QUEUE_PTR_W-1:0] QUEUE_PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);

  localparam int MOD_SH    = 20;
  localparam int RECIP_W   = MOD_SH - 1;
  localparam int MOD_W     = IN_ANG_W + RECIP_W;
  localparam int MOD_RECIP = (1 << MOD_SH) / ANGLE_STEPS;

  localparam logic [ANG_W:0] ANGLE_STEPS_W = (ANG_W + 1)'(ANGLE_STEPS);

  localparam logic [RADIUS_W-1:0] MAJOR_RADIUS_RST = 16'd6400;
  localparam logic [RADIUS_W-1:0] MINOR_RADIUS_RST = 16'd1280;
  localparam logic [ANG_W-1:0]    MAJOR_STEP_RST   = ANG_W'(20 % ANGLE_STEPS);
  localparam logic [ANG_W-1:0]    MINOR_STEP_RST   = ANG_W'(20 % ANGLE_STEPS);

  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = PI_Q30 / 64'd2;
  localparam logic [63:0] TWO_PI_Q30  = PI_Q30 * 64'd2;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAJOR_RADIUS = 2'd0,
    REG_MINOR_RADIUS = 2'd1,
    REG_MAJOR_STEP   = 2'd2,
    REG_MINOR_STEP   = 2'd3
  } cfg_reg_e;

  typedef enum logic [CORNER_W-1:0] {
    CORNER_BASE  = 2'd0,
    CORNER_MAJOR = 2'd1,
    CORNER_BOTH  = 2'd2,
    CORNER_MINOR = 2'd3
  } corner_e;

  typedef struct packed {
    logic [ANG_W-1:0] u0;
    logic [ANG_W-1:0] u1;
    logic [ANG_W-1:0] v0;
    logic [ANG_W-1:0] v1;
  } cell_t;

  typedef logic [ANGLE_STEPS-1:0][TRIG_W-1:0] trig_tab_t;

  // Reduces a raw angle modulo the number of angle steps: reciprocal
  // multiply, then at most one correction.
  function automatic logic [ANG_W-1:0] mod_angle(input logic [IN_ANG_W-1:0] x);
    logic [MOD_W-1:0] xw;
    logic [MOD_W-1:0] prod;
    logic [MOD_W-1:0] rem;
    xw   = MOD_W'(x);
    prod = xw * MOD_W'(MOD_RECIP);
    rem  = xw - ((prod >> MOD_SH) * MOD_W'(ANGLE_STEPS));
    if (rem >= MOD_W'(ANGLE_STEPS)) begin
      rem = rem - MOD_W'(ANGLE_STEPS);
    end
    return rem[ANG_W-1:0];
  endfunction

  // Adds two reduced angles and wraps once.
  function automatic logic [ANG_W-1:0] wrap_add(input logic [ANG_W-1:0] a,
                                                input logic [ANG_W-1:0] b);
    logic [ANG_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= ANGLE_STEPS_W) begin
      s = s - ANGLE_STEPS_W;
    end
    return s[ANG_W-1:0];
  endfunction

  // Sine in Q1.15 of an angle in [0, 2*pi) given in Q30.
  function automatic logic [TRIG_W-1:0] sin_q15(input logic [63:0] a_in);
    logic        neg;
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] m;
    a   = a_in;
    neg = 1'b0;
    if (a >= PI_Q30) begin
      a   = a - PI_Q30;
      neg = 1'b1;
    end
    if (a > HALF_PI_Q30) begin
      a = PI_Q30 - a;
    end
    x2 = (a * a) >> 30;
    s  = ONE_Q30;
    s  = ONE_Q30 - ((s * x2) >> 30) / 64'd156;
    s  = ONE_Q30 - ((s * x2) >> 30) / 64'd110;
    s  = ONE_Q30 - ((s * x2) >> 30) / 64'd72;
    s  = ONE_Q30 - ((s * x2) >> 30) / 64'd42;
    s  = ONE_Q30 - ((s * x2) >> 30) / 64'd20;
    s  = ONE_Q30 - ((s * x2) >> 30) / 64'd6;
    m  = (((s * a) >> 30) + 64'd16384) >> 15;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return neg ? TRIG_W'(-m) : TRIG_W'(m);
  endfunction

  function automatic trig_tab_t build_sin_tab();
    trig_tab_t   t;
    logic [63:0] a;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      a    = (TWO_PI_Q30 * 64'(k)) / 64'(ANGLE_STEPS);
      t[k] = sin_q15(a);
    end
    return t;
  endfunction

  function automatic trig_tab_t build_cos_tab();
    trig_tab_t   t;
    logic [63:0] c;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      c = (TWO_PI_Q30 * 64'(k)) / 64'(ANGLE_STEPS) + HALF_PI_Q30;
      if (c >= TWO_PI_Q30) begin
        c = c - TWO_PI_Q30;
      end
      t[k] = sin_q15(c);
    end
    return t;
  endfunction

  localparam trig_tab_t SIN_TAB = build_sin_tab();
  localparam trig_tab_t COS_TAB = build_cos_tab();

endpackage

>>> rtl/tqvg_front.sv
// ----------------------------------------------------------------------------
// Torus quad vertex generator front end
// Accepts a cell request, reduces its angles and forms the four corner angles,
// then hands the cell to the queue.
// ----------------------------------------------------------------------------
module tqvg_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [tqvg_pkg::IN_ANG_W-1:0] major_angle_i,
  input  logic [tqvg_pkg::IN_ANG_W-1:0] minor_angle_i,
  input  logic [tqvg_pkg::ANG_W-1:0]    major_step_i,
  input  logic [tqvg_pkg::ANG_W-1:0]    minor_step_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output tqvg_pkg::cell_t               cell_o
);

  logic                       valid_q, valid_d;
  logic [tqvg_pkg::ANG_W-1:0] u0_q;
  logic [tqvg_pkg::ANG_W-1:0] v0_q;
  logic                       accept;

  assign push_o = valid_q && !q_full_i;
  assign busy_o = valid_q && q_full_i;
  assign accept = start_i && !busy_o;
  assign valid_d = accept || (valid_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      u0_q <= tqvg_pkg::mod_angle(major_angle_i);
      v0_q <= tqvg_pkg::mod_angle(minor_angle_i);
    end
  end

  always_comb begin
    cell_o.u0 = u0_q;
    cell_o.u1 = tqvg_pkg::wrap_add(u0_q, major_step_i);
    cell_o.v0 = v0_q;
    cell_o.v1 = tqvg_pkg::wrap_add(v0_q, minor_step_i);
  end

endmodule

>>> rtl/tqvg_fifo.sv
// ----------------------------------------------------------------------------
// Torus quad vertex generator cell queue
// Short queue of prepared cells between the front end and the vertex engine.
// ----------------------------------------------------------------------------
module tqvg_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tqvg_pkg::cell_t cell_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output tqvg_pkg::cell_t cell_o
);

  tqvg_pkg::cell_t                  mem_q [tqvg_pkg::QUEUE_DEPTH];
  logic [tqvg_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [tqvg_pkg::QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [tqvg_pkg::QUEUE_CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == tqvg_pkg::QUEUE_FULL_CNT);
  assign valid_o = (count_q != '0);
  assign cell_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == tqvg_pkg::QUEUE_PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == tqvg_pkg::QUEUE_PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cell_i;
    end
  end

endmodule

>>> rtl/tqvg_back.sv
// ----------------------------------------------------------------------------
// Torus quad vertex generator vertex engine
// Walks the four corners of a queued cell, one per cycle, through a table
// lookup stage, a ring and height multiply stage, a coordinate multiply stage
// and a rounding and output stage.
// ----------------------------------------------------------------------------
module tqvg_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  tqvg_pkg::cell_t                     cell_i,
  output logic                                pop_o,
  input  logic [tqvg_pkg::RADIUS_W-1:0]       major_radius_i,
  input  logic [tqvg_pkg::RADIUS_W-1:0]       minor_radius_i,
  output logic                                valid_o,
  output logic signed [tqvg_pkg::POS_W-1:0]   pos_x_o,
  output logic signed [tqvg_pkg::POS_W-1:0]   pos_y_o,
  output logic signed [tqvg_pkg::POS_W-1:0]   pos_z_o,
  output logic [tqvg_pkg::CORNER_W-1:0]       corner_o,
  output logic                                last_corner_o
);

  localparam int QX_W = tqvg_pkg::PROD_W - 30;

  function automatic logic signed [tqvg_pkg::POS_W-1:0] sat_pos(
      input logic signed [QX_W-1:0] q);
    logic signed [QX_W-1:0] hi;
    logic signed [QX_W-1:0] lo;
    hi = QX_W'((1 << (tqvg_pkg::POS_W - 1)) - 1);
    lo = -hi - QX_W'(1);
    if (q > hi) begin
      return tqvg_pkg::POS_W'(hi);
    end else if (q < lo) begin
      return tqvg_pkg::POS_W'(lo);
    end
    return q[tqvg_pkg::POS_W-1:0];
  endfunction

  function automatic logic signed [QX_W-1:0] cut_xy(
      input logic signed [tqvg_pkg::PROD_W-1:0] p);
    logic signed [tqvg_pkg::PROD_W-1:0] b;
    b = p + (p[tqvg_pkg::PROD_W-1] ? tqvg_pkg::PROD_W'((64'd1 << 30) - 64'd1)
                                   : tqvg_pkg::PROD_W'(0));
    return $signed(b[tqvg_pkg::PROD_W-1:30]);
  endfunction

  function automatic logic signed [QX_W-1:0] cut_z(
      input logic signed [tqvg_pkg::TERM_W-1:0] p);
    logic signed [tqvg_pkg::TERM_W-1:0] b;
    b = p + (p[tqvg_pkg::TERM_W-1] ? tqvg_pkg::TERM_W'(32767)
                                   : tqvg_pkg::TERM_W'(0));
    return QX_W'($signed(b[tqvg_pkg::TERM_W-1:15]));
  endfunction

  // Corner sequencer.
  tqvg_pkg::cell_t            cur_q;
  logic                       cur_valid_q, cur_valid_d;
  tqvg_pkg::corner_e          corner_q, corner_d;
  logic                       load;
  logic [tqvg_pkg::ANG_W-1:0] sel_u;
  logic [tqvg_pkg::ANG_W-1:0] sel_v;

  // Lookup stage.
  logic                              a_valid_q;
  tqvg_pkg::corner_e                 a_corner_q;
  logic signed [tqvg_pkg::TRIG_W-1:0] a_cos_u_q, a_sin_u_q, a_cos_v_q, a_sin_v_q;

  // Ring and height stage.
  logic                               b_valid_q;
  tqvg_pkg::corner_e                  b_corner_q;
  logic signed [tqvg_pkg::TRIG_W-1:0] b_cos_u_q, b_sin_u_q;
  logic signed [tqvg_pkg::RING_W-1:0] b_ring_q, b_ring_d;
  logic signed [tqvg_pkg::TERM_W-1:0] b_z_q, b_z_d;
  logic signed [tqvg_pkg::RADIUS_W:0] minor_s;
  logic signed [tqvg_pkg::TERM_W-1:0] minor_cos;
  logic signed [tqvg_pkg::RING_W-1:0] major_term;

  // Coordinate stage.
  logic                               c_valid_q;
  tqvg_pkg::corner_e                  c_corner_q;
  logic signed [tqvg_pkg::PROD_W-1:0] c_px_q, c_py_q;
  logic signed [tqvg_pkg::TERM_W-1:0] c_z_q;

  // Output stage.
  logic                             out_valid_q;
  tqvg_pkg::corner_e                out_corner_q;
  logic signed [tqvg_pkg::POS_W-1:0] out_x_q, out_y_q, out_z_q;

  assign load  = !cur_valid_q || (corner_q == tqvg_pkg::CORNER_MINOR);
  assign pop_o = load && q_valid_i;

  always_comb begin
    cur_valid_d = load ? q_valid_i : 1'b1;
    corner_d    = load ? tqvg_pkg::CORNER_BASE
                       : tqvg_pkg::corner_e'(corner_q + 2'd1);
  end

  always_comb begin
    unique case (corner_q)
      tqvg_pkg::CORNER_BASE: begin
        sel_u = cur_q.u0;
        sel_v = cur_q.v0;
      end
      tqvg_pkg::CORNER_MAJOR: begin
        sel_u = cur_q.u1;
        sel_v = cur_q.v0;
      end
      tqvg_pkg::CORNER_BOTH: begin
        sel_u = cur_q.u1;
        sel_v = cur_q.v1;
      end
      tqvg_pkg::CORNER_MINOR: begin
        sel_u = cur_q.u0;
        sel_v = cur_q.v1;
      end
      default: begin
        sel_u = cur_q.u0;
        sel_v = cur_q.v0;
      end
    endcase
  end

  always_comb begin
    minor_s    = $signed({1'b0, minor_radius_i});
    minor_cos  = minor_s * a_cos_v_q;
    major_term = $signed({{(tqvg_pkg::RING_W - tqvg_pkg::RADIUS_W - tqvg_pkg::TRIG_W + 1){1'b0}},
                          major_radius_i, {(tqvg_pkg::TRIG_W - 1){1'b0}}});
    b_ring_d   = major_term + tqvg_pkg::RING_W'(minor_cos);
    b_z_d      = minor_s * a_sin_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      corner_q    <= tqvg_pkg::CORNER_BASE;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      corner_q    <= corner_d;
      a_valid_q   <= cur_valid_q;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      out_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= cell_i;
    end
    a_corner_q   <= corner_q;
    a_cos_u_q    <= $signed(tqvg_pkg::COS_TAB[sel_u]);
    a_sin_u_q    <= $signed(tqvg_pkg::SIN_TAB[sel_u]);
    a_cos_v_q    <= $signed(tqvg_pkg::COS_TAB[sel_v]);
    a_sin_v_q    <= $signed(tqvg_pkg::SIN_TAB[sel_v]);
    b_corner_q   <= a_corner_q;
    b_cos_u_q    <= a_cos_u_q;
    b_sin_u_q    <= a_sin_u_q;
    b_ring_q     <= b_ring_d;
    b_z_q        <= b_z_d;
    c_corner_q   <= b_corner_q;
    c_px_q       <= b_ring_q * b_cos_u_q;
    c_py_q       <= b_ring_q * b_sin_u_q;
    c_z_q        <= b_z_q;
    out_corner_q <= c_corner_q;
    out_x_q      <= sat_pos(cut_xy(c_px_q));
    out_y_q      <= sat_pos(cut_xy(c_py_q));
    out_z_q      <= sat_pos(cut_z(c_z_q));
  end

  assign valid_o       = out_valid_q;
  assign pos_x_o       = out_x_q;
  assign pos_y_o       = out_y_q;
  assign pos_z_o       = out_z_q;
  assign corner_o      = out_corner_q;
  assign last_corner_o = (out_corner_q == tqvg_pkg::CORNER_MINOR);

endmodule

>>> rtl/torus_quad_vertex_generator_top.sv
// ----------------------------------------------------------------------------
// Torus quad vertex generator
// Turns one torus grid cell into the four corner vertices of its quad.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Payload
//  request   in         start high, busy low     major_angle_i, minor_angle_i
//  vertex    out        valid_o, one cycle       pos_x_o, pos_y_o, pos_z_o,
//                                                corner_o, last_corner_o
//  config    in         cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// The vertex engine issues the four corners of a cell one per cycle.
// A cell passes the front register and the queue before the engine takes it.
// Reset loads the default radii and steps; there is no clearing pass.
// Busy rises only when the front stage holds a cell and the queue is full.
// ----------------------------------------------------------------------------
module torus_quad_vertex_generator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [tqvg_pkg::IN_ANG_W-1:0]       major_angle_i,
  input  logic [tqvg_pkg::IN_ANG_W-1:0]       minor_angle_i,
  input  logic                                cfg_we_i,
  input  logic [tqvg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tqvg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic                                valid_o,
  output logic signed [tqvg_pkg::POS_W-1:0]   pos_x_o,
  output logic signed [tqvg_pkg::POS_W-1:0]   pos_y_o,
  output logic signed [tqvg_pkg::POS_W-1:0]   pos_z_o,
  output logic [tqvg_pkg::CORNER_W-1:0]       corner_o,
  output logic                                last_corner_o
);

  logic [tqvg_pkg::RADIUS_W-1:0] major_radius_q;
  logic [tqvg_pkg::RADIUS_W-1:0] minor_radius_q;
  logic [tqvg_pkg::ANG_W-1:0]    major_step_q;
  logic [tqvg_pkg::ANG_W-1:0]    minor_step_q;

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  tqvg_pkg::cell_t front_cell;
  tqvg_pkg::cell_t queue_cell;

  // Steps are held already reduced modulo the number of angle steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_radius_q <= tqvg_pkg::MAJOR_RADIUS_RST;
      minor_radius_q <= tqvg_pkg::MINOR_RADIUS_RST;
      major_step_q   <= tqvg_pkg::MAJOR_STEP_RST;
      minor_step_q   <= tqvg_pkg::MINOR_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (tqvg_pkg::cfg_reg_e'(cfg_idx_i))
        tqvg_pkg::REG_MAJOR_RADIUS: major_radius_q <= cfg_wdata_i[tqvg_pkg::RADIUS_W-1:0];
        tqvg_pkg::REG_MINOR_RADIUS: minor_radius_q <= cfg_wdata_i[tqvg_pkg::RADIUS_W-1:0];
        tqvg_pkg::REG_MAJOR_STEP:
          major_step_q <= tqvg_pkg::mod_angle(cfg_wdata_i[tqvg_pkg::STEP_W-1:0]);
        tqvg_pkg::REG_MINOR_STEP:
          minor_step_q <= tqvg_pkg::mod_angle(cfg_wdata_i[tqvg_pkg::STEP_W-1:0]);
        default: ;
      endcase
    end
  end

  tqvg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .major_angle_i (major_angle_i),
    .minor_angle_i (minor_angle_i),
    .major_step_i  (major_step_q),
    .minor_step_i  (minor_step_q),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .cell_o        (front_cell)
  );

  tqvg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cell_i  (front_cell),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cell_o  (queue_cell)
  );

  tqvg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .cell_i         (queue_cell),
    .pop_o          (q_pop),
    .major_radius_i (major_radius_q),
    .minor_radius_i (minor_radius_q),
    .valid_o        (valid_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .corner_o       (corner_o),
    .last_corner_o  (last_corner_o)
  );

endmodule

>>> rtl/tqvg_checker.sv
// ----------------------------------------------------------------------------
// Torus quad vertex generator port checker
// Watches the vertex stream on the top level ports for corner order, the last
// corner flag and the heights that corners sharing a minor angle must repeat.
// ----------------------------------------------------------------------------
module tqvg_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                valid_o,
  input logic signed [tqvg_pkg::POS_W-1:0]   pos_z_o,
  input logic [tqvg_pkg::CORNER_W-1:0]       corner_o,
  input logic                                last_corner_o
);

  a_corner_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (corner_o != tqvg_pkg::CORNER_MINOR)
    |=> valid_o && (corner_o == $past(corner_o) + 2'd1))
    else $error("Quad corners did not follow each other in consecutive cycles.");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_corner_o == (corner_o == tqvg_pkg::CORNER_MINOR)))
    else $error("Last corner flag does not match the corner index.");

  a_height_major: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (corner_o == tqvg_pkg::CORNER_MAJOR) |-> (pos_z_o == $past(pos_z_o)))
    else $error("Second corner height differs from the first corner height.");

  a_height_minor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (corner_o == tqvg_pkg::CORNER_MINOR) |-> (pos_z_o == $past(pos_z_o)))
    else $error("Fourth corner height differs from the third corner height.");

endmodule

bind torus_quad_vertex_generator_top tqvg_checker u_tqvg_checker (.*);

>>> tb/torus_quad_vertex_generator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Torus quad vertex generator testbench
// Sends grid cells through the request port under several radius and step
// settings and checks every vertex against an independent fixed-point model
// of the torus, corner order and wrap-around included.
// ----------------------------------------------------------------------------
module torus_quad_vertex_generator_top_tb;

  localparam int          NUM_ANGLES  = tqvg_pkg::ANGLE_STEPS;
  localparam bit [63:0]   PI_Q        = 64'd3373259426;
  localparam bit [63:0]   HALF_PI_Q   = PI_Q / 64'd2;
  localparam bit [63:0]   TWO_PI_Q    = PI_Q * 64'd2;
  localparam bit [63:0]   UNIT_Q      = 64'd1 << 30;
  localparam longint      POS_MAX     = 131071;
  localparam longint      POS_MIN     = -131072;
  localparam int          CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [tqvg_pkg::POS_W-1:0] x;
    logic signed [tqvg_pkg::POS_W-1:0] y;
    logic signed [tqvg_pkg::POS_W-1:0] z;
    tqvg_pkg::corner_e                 corner;
    logic                              last;
  } vertex_t;

  class torus_quad_book;
    int               sine[NUM_ANGLES];
    int               cosine[NUM_ANGLES];
    logic [15:0]      major_r;
    logic [15:0]      minor_r;
    logic [8:0]       major_du;
    logic [8:0]       minor_dv;
    vertex_t          pending[$];
    int               errors;
    int               cells;
    int               vertices;

    function new();
      bit [63:0] a;
      bit [63:0] c;
      for (int k = 0; k < NUM_ANGLES; k++) begin
        a = (TWO_PI_Q * 64'(k)) / 64'(NUM_ANGLES);
        c = a + HALF_PI_Q;
        if (c >= TWO_PI_Q) begin
          c = c - TWO_PI_Q;
        end
        sine[k]   = q15_sine(a);
        cosine[k] = q15_sine(c);
      end
      major_r  = 16'd6400;
      minor_r  = 16'd1280;
      major_du = 9'd20;
      minor_dv = 9'd20;
    endfunction

    // Folds the angle into the first quadrant and sums the Taylor series
    // from the highest term down, truncating at every step.
    function int q15_sine(bit [63:0] angle);
      bit        negate;
      bit [63:0] a;
      bit [63:0] sq;
      bit [63:0] s;
      bit [63:0] mag;
      a      = angle;
      negate = 1'b0;
      if (a >= PI_Q) begin
        a      = a - PI_Q;
        negate = 1'b1;
      end
      if (a > HALF_PI_Q) begin
        a = PI_Q - a;
      end
      sq = (a * a) >> 30;
      s  = UNIT_Q;
      for (int n = 13; n >= 3; n -= 2) begin
        s = UNIT_Q - ((s * sq) >> 30) / 64'(n * (n - 1));
      end
      mag = (((s * a) >> 30) + 64'd16384) >> 15;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      return negate ? -int'(mag) : int'(mag);
    endfunction

    function void set_reg(tqvg_pkg::cfg_reg_e idx, logic [15:0] data);
      case (idx)
        tqvg_pkg::REG_MAJOR_RADIUS: major_r  = data;
        tqvg_pkg::REG_MINOR_RADIUS: minor_r  = data;
        tqvg_pkg::REG_MAJOR_STEP:   major_du = data[8:0];
        tqvg_pkg::REG_MINOR_STEP:   minor_dv = data[8:0];
        default: ;
      endcase
    endfunction

    function logic signed [tqvg_pkg::POS_W-1:0] clip(longint value);
      if (value > POS_MAX) begin
        value = POS_MAX;
      end
      if (value < POS_MIN) begin
        value = POS_MIN;
      end
      return value[tqvg_pkg::POS_W-1:0];
    endfunction

    function void add_vertex(int ua, int va, tqvg_pkg::corner_e c);
      vertex_t v;
      longint  ring;
      ring     = longint'(major_r) * 32768 + longint'(minor_r) * longint'(cosine[va]);
      v.x      = clip((ring * longint'(cosine[ua])) / (longint'(1) << 30));
      v.y      = clip((ring * longint'(sine[ua])) / (longint'(1) << 30));
      v.z      = clip((longint'(minor_r) * longint'(sine[va])) / 32768);
      v.corner = c;
      v.last   = (c == tqvg_pkg::CORNER_MINOR);
      pending.push_back(v);
    endfunction

    function void note_cell(logic [8:0] u, logic [8:0] v);
      int u0;
      int u1;
      int v0;
      int v1;
      u0 = int'(u) % NUM_ANGLES;
      u1 = (int'(u) + int'(major_du)) % NUM_ANGLES;
      v0 = int'(v) % NUM_ANGLES;
      v1 = (int'(v) + int'(minor_dv)) % NUM_ANGLES;
      add_vertex(u0, v0, tqvg_pkg::CORNER_BASE);
      add_vertex(u1, v0, tqvg_pkg::CORNER_MAJOR);
      add_vertex(u1, v1, tqvg_pkg::CORNER_BOTH);
      add_vertex(u0, v1, tqvg_pkg::CORNER_MINOR);
      cells++;
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task check_vertex(vertex_t got);
      vertex_t want;
      vertices++;
      if (pending.size() == 0) begin
        report($sformatf("vertex with no request outstanding (corner %0d)", got.corner));
      end else begin
        want = pending.pop_front();
        if (got.x !== want.x) begin
          report($sformatf("corner %0d x: got %0d, want %0d", want.corner, got.x, want.x));
        end
        if (got.y !== want.y) begin
          report($sformatf("corner %0d y: got %0d, want %0d", want.corner, got.y, want.y));
        end
        if (got.z !== want.z) begin
          report($sformatf("corner %0d z: got %0d, want %0d", want.corner, got.z, want.z));
        end
        if (got.corner !== want.corner) begin
          report($sformatf("corner index: got %0d, want %0d", got.corner, want.corner));
        end
        if (got.last !== want.last) begin
          report($sformatf("corner %0d last flag: got %b, want %b",
                           want.corner, got.last, want.last));
        end
      end
    endtask
  endclass

  logic                                clk_i;
  logic                                rst_ni;
  logic                                start;
  logic                                busy;
  logic [tqvg_pkg::IN_ANG_W-1:0]       major_angle_i;
  logic [tqvg_pkg::IN_ANG_W-1:0]       minor_angle_i;
  logic                                cfg_we_i;
  logic [tqvg_pkg::CFG_IDX_W-1:0]      cfg_idx_i;
  logic [tqvg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i;
  logic                                valid_o;
  logic signed [tqvg_pkg::POS_W-1:0]   pos_x_o;
  logic signed [tqvg_pkg::POS_W-1:0]   pos_y_o;
  logic signed [tqvg_pkg::POS_W-1:0]   pos_z_o;
  logic [tqvg_pkg::CORNER_W-1:0]       corner_o;
  logic                                last_corner_o;

  torus_quad_book quad_book = new();
  int             settings_used;
  int             cycle_count;

  torus_quad_vertex_generator_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .major_angle_i (major_angle_i),
    .minor_angle_i (minor_angle_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .valid_o       (valid_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .corner_o      (corner_o),
    .last_corner_o (last_corner_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    vertex_t got;
    if (rst_ni === 1'b1 && valid_o === 1'b1) begin
      got.x      = pos_x_o;
      got.y      = pos_y_o;
      got.z      = pos_z_o;
      got.corner = tqvg_pkg::corner_e'(corner_o);
      got.last   = last_corner_o;
      quad_book.check_vertex(got);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run timed out after %0d cycles.", cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_cell(input logic [8:0] u, input logic [8:0] v);
    start         <= 1'b1;
    major_angle_i <= u;
    minor_angle_i <= v;
    do @(posedge clk_i); while (busy !== 1'b0);
    quad_book.note_cell(u, v);
  endtask

  task automatic pause_requests(input int cycles);
    start         <= 1'b0;
    major_angle_i <= 9'($urandom);
    minor_angle_i <= 9'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic maybe_pause(input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      pause_requests(1);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (quad_book.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [15:0] major_r, input logic [15:0] minor_r,
                                input logic [15:0] major_du, input logic [15:0] minor_dv);
    tqvg_pkg::cfg_reg_e regs[4];
    logic [15:0]        vals[4];
    regs = '{tqvg_pkg::REG_MAJOR_RADIUS, tqvg_pkg::REG_MINOR_RADIUS,
             tqvg_pkg::REG_MAJOR_STEP, tqvg_pkg::REG_MINOR_STEP};
    vals = '{major_r, minor_r, major_du, minor_dv};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= regs[i];
      cfg_wdata_i <= vals[i];
      quad_book.set_reg(regs[i], vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic random_cells(input int count, input int idle_pct, input logic bool_hold);
    logic [8:0] u;
    logic [8:0] v;
    for (int i = 0; i < count; i++) begin
      u = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359));
      v = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359));
      send_cell(u, v);
      if (bool_hold && i == count / 2) begin
        drain();
      end else begin
        maybe_pause(idle_pct);
      end
    end
  endtask

  initial begin
    logic [8:0] base_cells[12][2];
    base_cells = '{'{9'd0, 9'd0}, '{9'd359, 9'd359}, '{9'd511, 9'd511},
                   '{9'd360, 9'd0}, '{9'd0, 9'd360}, '{9'd90, 9'd270},
                   '{9'd180, 9'd180}, '{9'd270, 9'd90}, '{9'd345, 9'd350},
                   '{9'd256, 9'd255}, '{9'd255, 9'd256}, '{9'd45, 9'd135}};
    settings_used = 1;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    major_angle_i <= '0;
    minor_angle_i <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= tqvg_pkg::REG_MAJOR_RADIUS;
    cfg_wdata_i   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: extremes of both angles, wrap past 359, quadrant edges.
    foreach (base_cells[i]) begin
      send_cell(base_cells[i][0], base_cells[i][1]);
      maybe_pause(34);
    end
    drain();

    // Largest radii with zero steps: all four corners coincide.
    write_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    send_cell(9'd0, 9'd0);
    send_cell(9'd359, 9'd180);
    send_cell(9'd511, 9'd0);
    send_cell(9'd90, 9'd270);
    drain();

    // Zero major radius, steps of one turn and more, and a step register overfilled.
    write_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'd360);
    send_cell(9'd0, 9'd0);
    send_cell(9'd300, 9'd359);
    send_cell(9'd511, 9'd400);
    drain();
    write_settings(16'hFFFF, 16'd0, 16'd359, 16'd1);
    send_cell(9'd1, 9'd359);
    send_cell(9'd359, 9'd1);
    drain();

    write_settings(16'($urandom), 16'($urandom), 16'($urandom_range(1, 360)),
                   16'($urandom_range(1, 360)));
    random_cells(50, 34, 1'b1);
    drain();
    write_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_cells(50, 0, 1'b0);
    drain();
    write_settings(16'hFFFF, 16'hFFFF, 16'($urandom_range(1, 360)), 16'd360);
    random_cells(40, 34, 1'b0);
    drain();
    write_settings(16'($urandom), 16'($urandom), 16'($urandom_range(0, 511)),
                   16'($urandom_range(0, 511)));
    random_cells(60, 34, 1'b0);
    drain();
    write_settings(16'd6400, 16'd1280, 16'd20, 16'd20);
    random_cells(50, 34, 1'b0);
    drain();

    if (quad_book.pending.size() != 0) begin
      quad_book.report($sformatf("%0d vertices never arrived", quad_book.pending.size()));
    end
    $display("Checked %0d vertices from %0d cells over %0d register settings, %0d errors.",
             quad_book.vertices, quad_book.cells, settings_used, quad_book.errors);
    if (quad_book.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
